[rtl/tps_pkg.sv]
// Shared constants and helpers for the triangle plane splitter.
`default_nettype none
package tps_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int COEF_WIDTH_DEF  = 16;
    localparam int DIST_WIDTH      = 48;
    localparam int PLANE_C_RESET   = 16384;

    localparam logic [1:0] SIDE_TOP = 2'd0;
    localparam logic [1:0] SIDE_BOT = 2'd1;
    localparam logic [1:0] SIDE_ON  = 2'd2;

    localparam logic [1:0] KIND_TOP    = 2'd0;
    localparam logic [1:0] KIND_BOT    = 2'd1;
    localparam logic [1:0] KIND_BORDER = 2'd2;

    localparam logic [1:0] REG_PLANE_A    = 2'd0;
    localparam logic [1:0] REG_PLANE_B    = 2'd1;
    localparam logic [1:0] REG_PLANE_C    = 2'd2;
    localparam logic [1:0] REG_PLANE_DIST = 2'd3;

    localparam logic [2:0] CASE_DROP    = 3'd0;
    localparam logic [2:0] CASE_WHOLE   = 3'd1;
    localparam logic [2:0] CASE_TWO_ON  = 3'd2;
    localparam logic [2:0] CASE_ONE_CUT = 3'd3;
    localparam logic [2:0] CASE_TWO_CUT = 3'd4;

    function automatic logic [1:0] next_idx(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

[rtl/triangle_plane_split.sv]
// Top level: pipelined triangle-by-plane splitter with result serializer.
`default_nettype none
// Each accepted triangle is classified against the plane a*x+b*y+c*z-dist and
// split into up to four results (top/bottom pieces, then a border segment),
// delivered one per cycle while m_tready is high, on the m_ side with tlast on
// the final one. A new triangle can enter every cycle unless the output
// serializer stalls the pipeline: it holds a triangle until its final result
// is taken, and a dropped triangle yields no results. The edge-intersection
// divider resolves one quotient bit per pipeline stage. Plane registers are
// at byte addresses 0, 8, 16, 24 (a, b, c, dist); write them only while idle.
module triangle_plane_split #(
    parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = tps_pkg::COEF_WIDTH_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  wire         s_tvalid,
    output logic        s_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
    input  wire  [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z
    output logic [((9*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    // kind
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    import tps_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int KW    = COEF_WIDTH;
    localparam int TDW   = ((9*CW+7)/8)*8;
    localparam int PW    = CW + KW;
    localparam int SW    = ((PW + 2 > DIST_WIDTH) ? PW + 2 : DIST_WIDTH) + 1;
    localparam int DENW  = SW + 1;
    localparam int QW    = CW + 1;
    localparam int NLO   = DENW / 2;
    localparam int NHI   = DENW - NLO;
    localparam int NW    = DENW + QW;
    localparam int DPOS0 = 3;
    localparam int FPOS  = QW + 4;

    function automatic logic [3*CW-1:0] sel_pt(input logic [1:0] i,
                                               input logic [9*CW-1:0] v);
        logic [3*CW-1:0] r;
        case (i)
            2'd0:    r = v[0 +: 3*CW];
            2'd1:    r = v[3*CW +: 3*CW];
            default: r = v[6*CW +: 3*CW];
        endcase
        return r;
    endfunction

    function automatic logic signed [SW-1:0] sel_sv(input logic [1:0] i,
                                                    input logic signed [SW-1:0] a,
                                                    input logic signed [SW-1:0] b,
                                                    input logic signed [SW-1:0] c);
        logic signed [SW-1:0] r;
        case (i)
            2'd0:    r = a;
            2'd1:    r = b;
            default: r = c;
        endcase
        return r;
    endfunction

    // configuration
    logic signed [KW-1:0]         plane_a_reg, plane_b_reg, plane_c_reg;
    logic signed [DIST_WIDTH-1:0] plane_dist_reg;
    logic signed [KW-1:0]         coef [3];
    logic                         cfg_wr;

    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign coef[0] = plane_a_reg;
    assign coef[1] = plane_b_reg;
    assign coef[2] = plane_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_a_reg    <= '0;
            plane_b_reg    <= '0;
            plane_c_reg    <= KW'(PLANE_C_RESET);
            plane_dist_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                REG_PLANE_A:    plane_a_reg    <= pwdata[KW-1:0];
                REG_PLANE_B:    plane_b_reg    <= pwdata[KW-1:0];
                REG_PLANE_C:    plane_c_reg    <= pwdata[KW-1:0];
                REG_PLANE_DIST: plane_dist_reg <= pwdata[DIST_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_PLANE_A:    prdata = 64'({1'b0, plane_a_reg});
            REG_PLANE_B:    prdata = 64'({1'b0, plane_b_reg});
            REG_PLANE_C:    prdata = 64'({1'b0, plane_c_reg});
            REG_PLANE_DIST: prdata = 64'({1'b0, plane_dist_reg});
            default:        prdata = '0;
        endcase
    end

    logic adv;
    logic load_ok;

    // stage 1: products, stage 2: plane values
    logic                 s1_v_reg, s2_v_reg;
    logic [9*CW-1:0]      s1_vtx_reg, s2_vtx_reg;
    logic signed [PW-1:0] s1_prod_reg [9];
    logic signed [SW-1:0] s2_sv_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end else if (adv) begin
            s1_v_reg <= s_tvalid;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_vtx_reg <= s_tdata[9*CW-1:0];
            for (int j = 0; j < 9; j++) begin
                s1_prod_reg[j] <= coef[j % 3] * $signed(s_tdata[j*CW +: CW]);
            end
            s2_vtx_reg <= s1_vtx_reg;
            for (int i = 0; i < 3; i++) begin
                s2_sv_reg[i] <= SW'(s1_prod_reg[3*i]) + SW'(s1_prod_reg[3*i+1])
                              + SW'(s1_prod_reg[3*i+2]) - SW'(plane_dist_reg);
            end
        end
    end

    // classification
    logic [1:0] pos [3];
    logic [1:0] n_top, n_bot, n_on;
    logic [2:0] cls_case;
    logic [1:0] cls_side, cls_sidx;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (s2_sv_reg[i] == '0)      pos[i] = SIDE_ON;
            else if (s2_sv_reg[i][SW-1]) pos[i] = SIDE_BOT;
            else                         pos[i] = SIDE_TOP;
        end
        n_top = 2'(pos[0] == SIDE_TOP) + 2'(pos[1] == SIDE_TOP) + 2'(pos[2] == SIDE_TOP);
        n_bot = 2'(pos[0] == SIDE_BOT) + 2'(pos[1] == SIDE_BOT) + 2'(pos[2] == SIDE_BOT);
        n_on  = 2'(pos[0] == SIDE_ON) + 2'(pos[1] == SIDE_ON) + 2'(pos[2] == SIDE_ON);
        cls_case = CASE_TWO_CUT;
        cls_side = SIDE_TOP;
        cls_sidx = 2'd0;
        if (n_on == 2'd3) begin
            cls_case = CASE_DROP;
        end else if (n_top == 2'd3 || n_bot == 2'd3) begin
            cls_case = CASE_WHOLE;
            cls_side = pos[0];
        end else if (n_on == 2'd2) begin
            cls_case = CASE_TWO_ON;
            for (int i = 0; i < 3; i++) begin
                if (pos[i] != SIDE_ON) begin
                    cls_sidx = 2'(i);
                    cls_side = pos[i];
                end
            end
        end else if (n_on == 2'd1) begin
            for (int i = 0; i < 3; i++) begin
                if (pos[i] == SIDE_ON) cls_sidx = 2'(i);
            end
            if (n_top == 2'd1) begin
                cls_case = CASE_ONE_CUT;
                cls_side = pos[next_idx(cls_sidx)];
            end else begin
                cls_case = CASE_WHOLE;
                cls_side = (n_bot == 2'd2) ? SIDE_BOT : SIDE_TOP;
            end
        end else begin
            cls_side = (n_top == 2'd1) ? SIDE_TOP : SIDE_BOT;
            for (int i = 0; i < 3; i++) begin
                if (pos[i] == cls_side) cls_sidx = 2'(i);
            end
        end
    end

    // carried through positions 0 .. FPOS
    logic            c_v_reg    [0:FPOS];
    logic [9*CW-1:0] c_vtx_reg  [0:FPOS];
    logic [2:0]      c_case_reg [0:FPOS];
    logic [1:0]      c_side_reg [0:FPOS];
    logic [1:0]      c_sidx_reg [0:FPOS];
    logic signed [SW-1:0] p0_sv_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t <= FPOS; t++) c_v_reg[t] <= 1'b0;
        end else if (adv) begin
            c_v_reg[0] <= s2_v_reg;
            for (int t = 1; t <= FPOS; t++) c_v_reg[t] <= c_v_reg[t-1];
        end
    end

    // intersection setup from position 0
    logic [1:0]           st_n1, st_n2, pa_idx, qa_idx;
    logic [3*CW-1:0]      pa_pt, qa_pt, pb_pt, qb_pt;
    logic signed [SW-1:0] spa, sqa, spb, sqb;
    logic signed [DENW-1:0] numx [2];
    logic signed [DENW-1:0] difx [2];
    logic [DENW-1:0]      num_c [2];
    logic [DENW-1:0]      den_c [2];
    logic signed [QW-1:0] dx [6];
    logic [QW-1:0]        ad_c [6];
    logic                 dneg_c [6];
    logic [CW-1:0]        p_c [6];

    always_comb begin
        st_n1  = next_idx(c_sidx_reg[0]);
        st_n2  = next_idx(st_n1);
        pa_idx = (c_case_reg[0] == CASE_ONE_CUT) ? st_n1 : c_sidx_reg[0];
        qa_idx = (c_case_reg[0] == CASE_ONE_CUT) ? st_n2 : st_n1;
        pa_pt  = sel_pt(pa_idx, c_vtx_reg[0]);
        qa_pt  = sel_pt(qa_idx, c_vtx_reg[0]);
        pb_pt  = sel_pt(c_sidx_reg[0], c_vtx_reg[0]);
        qb_pt  = sel_pt(st_n2, c_vtx_reg[0]);
        spa    = sel_sv(pa_idx, p0_sv_reg[0], p0_sv_reg[1], p0_sv_reg[2]);
        sqa    = sel_sv(qa_idx, p0_sv_reg[0], p0_sv_reg[1], p0_sv_reg[2]);
        spb    = sel_sv(c_sidx_reg[0], p0_sv_reg[0], p0_sv_reg[1], p0_sv_reg[2]);
        sqb    = sel_sv(st_n2, p0_sv_reg[0], p0_sv_reg[1], p0_sv_reg[2]);
        numx[0] = DENW'(spa);
        numx[1] = DENW'(spb);
        difx[0] = DENW'(spa) - DENW'(sqa);
        difx[1] = DENW'(spb) - DENW'(sqb);
        for (int u = 0; u < 2; u++) begin
            num_c[u] = numx[u][DENW-1] ? DENW'(-numx[u]) : DENW'(numx[u]);
            den_c[u] = difx[u][DENW-1] ? DENW'(-difx[u]) : DENW'(difx[u]);
        end
        for (int k = 0; k < 3; k++) begin
            dx[k]    = QW'($signed(qa_pt[k*CW +: CW])) - QW'($signed(pa_pt[k*CW +: CW]));
            dx[k+3]  = QW'($signed(qb_pt[k*CW +: CW])) - QW'($signed(pb_pt[k*CW +: CW]));
            p_c[k]   = pa_pt[k*CW +: CW];
            p_c[k+3] = pb_pt[k*CW +: CW];
        end
        for (int l = 0; l < 6; l++) begin
            dneg_c[l] = dx[l][QW-1];
            ad_c[l]   = dneg_c[l] ? QW'(-dx[l]) : QW'(dx[l]);
        end
    end

    // lane registers
    logic [CW-1:0]        l_p_reg    [1:FPOS-1][6];
    logic                 l_dneg_reg [1:FPOS-1][6];
    logic [DENW-1:0]      den_reg    [1:FPOS-1][2];
    logic [DENW-1:0]      num_reg    [2];
    logic [QW-1:0]        ad_reg     [6];
    logic [NLO+QW-1:0]    pplo_reg   [6];
    logic [NHI+QW-1:0]    pphi_reg   [6];
    logic [DENW-1:0]      rem_reg    [DPOS0:FPOS-1][6];
    logic [QW-1:0]        low_reg    [DPOS0:FPOS-1][6];
    logic [QW-1:0]        quo_reg    [DPOS0:FPOS-1][6];
    logic [DENW-1:0]      rem_next   [DPOS0+1:FPOS-1][6];
    logic [QW-1:0]        quo_next   [DPOS0+1:FPOS-1][6];
    logic [NW-1:0]        nsum       [6];
    logic [CW-1:0]        f_r_reg    [6];

    always_comb begin
        logic [DENW:0] trial;
        logic          ge;
        for (int l = 0; l < 6; l++) begin
            nsum[l] = (NW'(pphi_reg[l]) << NLO) + NW'(pplo_reg[l]);
        end
        for (int t = DPOS0 + 1; t <= FPOS - 1; t++) begin
            for (int l = 0; l < 6; l++) begin
                trial = {rem_reg[t-1][l], low_reg[t-1][l][QW+DPOS0-t]};
                ge    = trial >= {1'b0, den_reg[t-1][l/3]};
                rem_next[t][l] = ge ? DENW'(trial - {1'b0, den_reg[t-1][l/3]})
                                    : trial[DENW-1:0];
                quo_next[t][l] = quo_reg[t-1][l]
                               | (ge ? (QW'(1) << (QW + DPOS0 - t)) : '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_vtx_reg[0]  <= s2_vtx_reg;
            c_case_reg[0] <= cls_case;
            c_side_reg[0] <= cls_side;
            c_sidx_reg[0] <= cls_sidx;
            p0_sv_reg     <= s2_sv_reg;
            for (int t = 1; t <= FPOS; t++) begin
                c_vtx_reg[t]  <= c_vtx_reg[t-1];
                c_case_reg[t] <= c_case_reg[t-1];
                c_side_reg[t] <= c_side_reg[t-1];
                c_sidx_reg[t] <= c_sidx_reg[t-1];
            end
            for (int u = 0; u < 2; u++) begin
                num_reg[u]    <= num_c[u];
                den_reg[1][u] <= den_c[u];
            end
            for (int l = 0; l < 6; l++) begin
                ad_reg[l]        <= ad_c[l];
                l_p_reg[1][l]    <= p_c[l];
                l_dneg_reg[1][l] <= dneg_c[l];
                pplo_reg[l] <= num_reg[l/3][NLO-1:0] * ad_reg[l];
                pphi_reg[l] <= num_reg[l/3][DENW-1:NLO] * ad_reg[l];
                rem_reg[DPOS0][l] <= nsum[l][NW-1:QW];
                low_reg[DPOS0][l] <= nsum[l][QW-1:0];
                quo_reg[DPOS0][l] <= '0;
                f_r_reg[l] <= l_p_reg[FPOS-1][l]
                            + (l_dneg_reg[FPOS-1][l] ? (~quo_reg[FPOS-1][l][CW-1:0] + 1'b1)
                                                     : quo_reg[FPOS-1][l][CW-1:0]);
            end
            for (int t = 2; t <= FPOS - 1; t++) begin
                l_p_reg[t]    <= l_p_reg[t-1];
                l_dneg_reg[t] <= l_dneg_reg[t-1];
                den_reg[t]    <= den_reg[t-1];
            end
            for (int t = DPOS0 + 1; t <= FPOS - 1; t++) begin
                rem_reg[t] <= rem_next[t];
                low_reg[t] <= low_reg[t-1];
                quo_reg[t] <= quo_next[t];
            end
        end
    end

    // result list for the triangle at the last position
    logic [1:0]      b_kind [4];
    logic [9*CW-1:0] b_pts  [4];
    logic [2:0]      b_cnt;
    logic [1:0]      f_n1, f_n2;
    logic [3*CW-1:0] vs, vn1, vn2, ia, ib, ea, eb;
    logic [1:0]      other;
    logic [3*CW-1:0] zpt;

    always_comb begin
        zpt   = '0;
        f_n1  = next_idx(c_sidx_reg[FPOS]);
        f_n2  = next_idx(f_n1);
        vs    = sel_pt(c_sidx_reg[FPOS], c_vtx_reg[FPOS]);
        vn1   = sel_pt(f_n1, c_vtx_reg[FPOS]);
        vn2   = sel_pt(f_n2, c_vtx_reg[FPOS]);
        ia    = {f_r_reg[2], f_r_reg[1], f_r_reg[0]};
        ib    = {f_r_reg[5], f_r_reg[4], f_r_reg[3]};
        ea    = (c_sidx_reg[FPOS] == 2'd0) ? vn1 : sel_pt(2'd0, c_vtx_reg[FPOS]);
        eb    = (c_sidx_reg[FPOS] == 2'd2) ? vn2 : sel_pt(2'd2, c_vtx_reg[FPOS]);
        other = (c_side_reg[FPOS] == SIDE_TOP) ? SIDE_BOT : SIDE_TOP;
        for (int r = 0; r < 4; r++) begin
            b_kind[r] = KIND_TOP;
            b_pts[r]  = '0;
        end
        b_cnt = 3'd0;
        case (c_case_reg[FPOS])
            CASE_WHOLE: begin
                b_kind[0] = c_side_reg[FPOS];
                b_pts[0]  = c_vtx_reg[FPOS];
                b_cnt     = 3'd1;
            end
            CASE_TWO_ON: begin
                b_kind[0] = c_side_reg[FPOS];
                b_pts[0]  = c_vtx_reg[FPOS];
                b_kind[1] = KIND_BORDER;
                b_pts[1]  = {zpt, eb, ea};
                b_cnt     = 3'd2;
            end
            CASE_ONE_CUT: begin
                b_kind[0] = KIND_BOT;
                b_kind[1] = KIND_TOP;
                if (c_side_reg[FPOS] == SIDE_BOT) begin
                    b_pts[0] = {ia, vn1, vs};
                    b_pts[1] = {ia, vn2, vs};
                end else begin
                    b_pts[0] = {ia, vn2, vs};
                    b_pts[1] = {ia, vn1, vs};
                end
                b_kind[2] = KIND_BORDER;
                b_pts[2]  = {zpt, ia, vs};
                b_cnt     = 3'd3;
            end
            CASE_TWO_CUT: begin
                if (ia == vs && ib == vs) begin
                    b_kind[0] = other;
                    b_pts[0]  = c_vtx_reg[FPOS];
                    b_cnt     = 3'd1;
                end else begin
                    b_kind[0] = c_side_reg[FPOS];
                    b_pts[0]  = {ib, ia, vs};
                    b_kind[1] = other;
                    b_pts[1]  = {ib, vn1, ia};
                    b_kind[2] = other;
                    b_pts[2]  = {vn2, vn1, ib};
                    b_kind[3] = KIND_BORDER;
                    b_pts[3]  = {zpt, ib, ia};
                    b_cnt     = 3'd4;
                end
            end
            default: b_cnt = 3'd0;
        endcase
    end

    // output serializer
    logic [1:0]      e_kind_reg [4];
    logic [9*CW-1:0] e_pts_reg  [4];
    logic [2:0]      e_cnt_reg;
    logic [1:0]      e_idx_reg;
    logic            e_busy_reg;

    assign m_tvalid = e_busy_reg;
    assign m_tdata  = TDW'(e_pts_reg[e_idx_reg]);
    assign m_tuser  = e_kind_reg[e_idx_reg];
    assign m_tlast  = ({1'b0, e_idx_reg} == (e_cnt_reg - 3'd1));
    assign load_ok  = !e_busy_reg || (m_tready && m_tlast);
    assign adv      = !c_v_reg[FPOS] || load_ok;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_busy_reg <= 1'b0;
            e_idx_reg  <= '0;
            e_cnt_reg  <= '0;
        end else if (load_ok && c_v_reg[FPOS]) begin
            e_busy_reg <= (b_cnt != 3'd0);
            e_idx_reg  <= '0;
            e_cnt_reg  <= b_cnt;
        end else if (e_busy_reg && m_tready) begin
            if (m_tlast) e_busy_reg <= 1'b0;
            else         e_idx_reg  <= e_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ok && c_v_reg[FPOS]) begin
            e_kind_reg <= b_kind;
            e_pts_reg  <= b_pts;
        end
    end

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        e_busy_reg |-> (e_cnt_reg != 3'd0 && {1'b0, e_idx_reg} < e_cnt_reg))
        else $error("serializer index beyond result count");

    a_border_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_BORDER |-> m_tlast)
        else $error("border segment not final result");

    a_border_p2_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_BORDER |-> m_tdata[6*CW +: 3*CW] == '0)
        else $error("border segment third point not zero");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        c_v_reg[FPOS] && !adv |=> c_v_reg[FPOS] && $stable(f_r_reg[0])
                                  && $stable(c_vtx_reg[FPOS]))
        else $error("stalled triangle changed");
endmodule
`default_nettype wire
